// ===== design/tdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned DUR_W       = 24;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CREATED  = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_IDLE     = 2'd3
  } kind_e;

  typedef enum logic {
    OP_CREATE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TAG_W-1:0]     tag;
  } entry_t;

  // ring index: (a + b) mod depth, both operands at most depth
  function automatic logic [PTR_W-1:0] ring_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/timer_deadline_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One-shot timer queue with a deadline-ordered ring store.
// Input stream: tuser = op (0 create, 1 tick); tdata = duration, tag. A create
// stores deadline = now + duration in order, or is rejected when the queue is
// full; a tick advances the time counter by one and fires every due timer,
// earliest first, equal deadlines in creation order.
// Output stream: tuser = kind, tdata = fired tag, tlast marks the final
// result of each request.
// One request is handled at a time; tready is high only while the sequencer
// is idle. A create into an empty queue is written straight to the head slot;
// otherwise one stored entry is read, compared against the new duration and
// moved per cycle. A tick reads and tests one entry per cycle while the
// output register is free.
// Reset empties the queue and clears the time counter; stored entries need no
// clearing. A stalled receiver holds the output register and the sequencer
// waits on it; the next request is taken as soon as the last result is loaded.
module timer_deadline_queue_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [23:0] duration, [39:24] tag
  input  wire logic        s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] fired_tag
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_FIRE  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam int unsigned TB = tdq_pkg::TIME_BITS;
  localparam int unsigned PW = tdq_pkg::PTR_W;
  localparam int unsigned CW = tdq_pkg::CNT_W;

  state_e state_q, state_d;

  logic [TB-1:0] time_q, time_d;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [PW-1:0] j_q, j_d;
  logic [PW-1:0] addr_q, addr_d;
  logic          pend_q, pend_d;
  logic [tdq_pkg::TAG_W-1:0] pend_tag_q, pend_tag_d;
  tdq_pkg::kind_e done_kind_q, done_kind_d;
  logic [tdq_pkg::DUR_W-1:0] key_q, key_d;
  tdq_pkg::entry_t new_q, new_d;

  tdq_pkg::entry_t mem [tdq_pkg::QUEUE_DEPTH];
  tdq_pkg::entry_t rd_q;
  logic            we;
  logic [PW-1:0]   waddr;
  tdq_pkg::entry_t wdata;

  logic            m_valid_q;
  tdq_pkg::kind_e  m_kind_q;
  logic [tdq_pkg::TAG_W-1:0] m_tag_q;
  logic            m_last_q;

  logic            out_free;
  logic            emit;
  tdq_pkg::kind_e  emit_kind;
  logic [tdq_pkg::TAG_W-1:0] emit_tag;
  logic            emit_last;

  logic            in_acc;
  logic [TB-1:0]   delta;
  logic            due;
  logic            at_end;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign delta  = rd_q.deadline - time_q;
  assign due    = (delta == '0) || delta[TB-1];
  assign at_end = (n_q == count_q);

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    head_d      = head_q;
    count_d     = count_q;
    n_d         = n_q;
    j_d         = j_q;
    addr_d      = addr_q;
    pend_d      = pend_q;
    pend_tag_d  = pend_tag_q;
    done_kind_d = done_kind_q;
    key_d       = key_q;
    new_d       = new_q;
    we          = 1'b0;
    waddr       = head_q;
    wdata       = new_q;
    emit        = 1'b0;
    emit_kind   = tdq_pkg::KIND_IDLE;
    emit_tag    = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == tdq_pkg::OP_TICK) begin
            time_d  = time_q + TB'(1);
            n_d     = '0;
            pend_d  = 1'b0;
            addr_d  = head_q;
            state_d = ST_FIRE;
          end else if (count_q == CW'(tdq_pkg::QUEUE_DEPTH)) begin
            done_kind_d = tdq_pkg::KIND_REJECTED;
            state_d     = ST_DONE;
          end else begin
            key_d          = s_axis_tdata[23:0];
            new_d.deadline = time_q + TB'(s_axis_tdata[23:0]);
            new_d.tag      = s_axis_tdata[39:24];
            done_kind_d    = tdq_pkg::KIND_CREATED;
            if (count_q == '0) begin
              we      = 1'b1;
              waddr   = head_q;
              wdata   = new_d;
              count_d = CW'(1);
              state_d = ST_DONE;
            end else begin
              j_d     = PW'(count_q - CW'(1));
              addr_d  = tdq_pkg::ring_add(CW'(head_q), count_q - CW'(1));
              state_d = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        we = 1'b1;
        if (delta > TB'(key_q)) begin
          waddr = tdq_pkg::ring_add(CW'(head_q), CW'(j_q) + CW'(1));
          wdata = rd_q;
          if (j_q == '0) begin
            state_d = ST_DONE;
            count_d = count_q + CW'(1);
          end else begin
            j_d    = j_q - PW'(1);
            addr_d = tdq_pkg::ring_add(CW'(head_q), CW'(j_q) - CW'(1));
          end
        end else begin
          waddr   = tdq_pkg::ring_add(CW'(head_q), CW'(j_q) + CW'(1));
          wdata   = new_q;
          count_d = count_q + CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_FIRE: begin
        if (out_free) begin
          if (!at_end && due) begin
            if (pend_q) begin
              emit      = 1'b1;
              emit_kind = tdq_pkg::KIND_FIRED;
              emit_tag  = pend_tag_q;
              emit_last = 1'b0;
            end
            pend_d     = 1'b1;
            pend_tag_d = rd_q.tag;
            n_d        = n_q + CW'(1);
            addr_d     = tdq_pkg::ring_add(CW'(addr_q), CW'(1));
          end else begin
            emit      = 1'b1;
            emit_kind = pend_q ? tdq_pkg::KIND_FIRED : tdq_pkg::KIND_IDLE;
            emit_tag  = pend_q ? pend_tag_q : '0;
            head_d    = tdq_pkg::ring_add(CW'(head_q), n_q);
            count_d   = count_q - n_q;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = done_kind_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // the entry moved at offset zero frees the head slot for the new timer
  logic head_fill;
  assign head_fill = (state_q == ST_SHIFT) && (j_q == '0) && (delta > TB'(key_q));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (head_fill) begin
      mem[head_q] <= new_q;
    end
    rd_q <= mem[addr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
      j_q         <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      done_kind_q <= tdq_pkg::KIND_CREATED;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      head_q      <= head_d;
      count_q     <= count_d;
      n_q         <= n_d;
      j_q         <= j_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      done_kind_q <= done_kind_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tag_q <= pend_tag_d;
    key_q      <= key_d;
    new_q      <= new_d;
    if (emit) begin
      m_kind_q <= emit_kind;
      m_tag_q  <= emit_tag;
      m_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tag_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(tdq_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE) |-> (n_q <= count_q))
    else $error("fire count above occupancy");

  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == tdq_pkg::OP_TICK)
      |=> (state_q == ST_FIRE) && (time_q == $past(time_q) + TB'(1)))
    else $error("tick did not advance time");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == tdq_pkg::OP_CREATE && count_q == CW'(tdq_pkg::QUEUE_DEPTH))
      |=> (state_q == ST_DONE) && (done_kind_q == tdq_pkg::KIND_REJECTED)
          && $stable(count_q))
    else $error("full queue did not reject");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |-> (state_d == ST_IDLE))
    else $error("final result while request still active");

endmodule

`default_nettype wire
